FILE: rtl/core/mrc_pkg.sv
// shared types and constants of the motion range calibrator
package mrc_pkg;

  localparam int POS_WIDTH_DEF = 32;
  localparam int VEL_W         = 16;
  localparam int NOW_W         = 32;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int NUM_W         = 12;
  localparam int SPD_W         = 8;
  localparam int FRAC_W        = 8;
  localparam int DVD_W         = NUM_W + FRAC_W;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_WAIT_X = 3'd1,
    PH_MEAS_X = 3'd2,
    PH_WAIT_Y = 3'd3,
    PH_MEAS_Y = 3'd4,
    PH_DONE   = 3'd5,
    PH_ABORT  = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_EVAL,
    ST_DIV_X_GO,
    ST_DIV_X_RUN,
    ST_DIV_Y_GO,
    ST_DIV_Y_RUN,
    ST_FIN
  } st_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_MOTION   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_EXPAND   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_NUM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED   = 3'd5;

  localparam logic [CFG_W-1:0] RST_MOTION_THR = 16'd128;
  localparam logic [CFG_W-1:0] RST_NO_MOTION  = 16'd5000;
  localparam logic [CFG_W-1:0] RST_NO_EXPAND  = 16'd3000;
  localparam logic [NUM_W-1:0] RST_SPEED_NUM  = 12'd600;
  localparam logic [SPD_W-1:0] RST_MAX_SPEED  = 8'd18;
  localparam logic [SPD_W-1:0] RST_MIN_SPEED  = 8'd5;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/core/mrc_div.sv
// shared restoring divider, one quotient bit per cycle
module mrc_div import mrc_pkg::*; #(
  parameter int DVS_W = POS_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [DVS_W:0] trial;
  logic [DVS_W:0] diff;
  logic           ge;

  assign trial = {rem, quo[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  // a zero divisor sets every quotient bit, which the clamp then caps
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

FILE: rtl/core/motion_range_calibrator.sv
// top level: sequencer, position datapath and output register of the calibrator
// Each accepted beat is a start command or a velocity sample and yields exactly one
// result beat carrying the phase and, once done, the clamped X and Y speeds. A beat
// passes ST_ACC (clear on a start, else integrate the velocity with saturation),
// ST_EVAL (compare range and timers, skipped for a start or when not active) and
// ST_FIN (hand the result to the output register). The sample that closes Y also
// runs two shared-divider passes, 20 quotient bits each, one bit per cycle. The
// output register lets the next beat be taken while a result still waits.
module motion_range_calibrator import mrc_pkg::*; #(
  parameter int POS_WIDTH = POS_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  opcode,
  input  logic signed [VEL_W-1:0] vel_x,
  input  logic signed [VEL_W-1:0] vel_y,
  input  logic [NOW_W-1:0]      now_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            phase,
  output logic                  speed_valid,
  output logic [SPD_W-1:0]      speed_x,
  output logic [SPD_W-1:0]      speed_y,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

  // configuration
  logic [CFG_W-1:0] motion_thr;
  logic [CFG_W-1:0] no_motion_ms;
  logic [CFG_W-1:0] no_expand_ms;
  logic [NUM_W-1:0] speed_num;
  logic [SPD_W-1:0] max_speed;
  logic [SPD_W-1:0] min_speed;

  // latched beat
  logic                    op_q;
  logic signed [VEL_W-1:0] v_q;
  logic [NOW_W-1:0]        now_q;

  // calibration state
  st_t                       st;
  st_t                       st_next;
  phase_t                    phase_q;
  logic signed [POS_WIDTH-1:0] pos_x;
  logic signed [POS_WIDTH-1:0] pos_x_max;
  logic signed [POS_WIDTH-1:0] pos_x_min;
  logic signed [POS_WIDTH-1:0] pos_y;
  logic signed [POS_WIDTH-1:0] pos_y_max;
  logic signed [POS_WIDTH-1:0] pos_y_min;
  logic [NOW_W-1:0]          last_time;
  logic [SPD_W-1:0]          speed_x_q;
  logic [SPD_W-1:0]          speed_y_q;

  // datapath
  logic                        axis_y;
  logic                        active;
  logic                        waiting;
  logic signed [POS_WIDTH-1:0] cur_pos;
  logic signed [POS_WIDTH-1:0] cur_max;
  logic signed [POS_WIDTH-1:0] cur_min;
  logic signed [POS_WIDTH:0]   sum;
  logic signed [POS_WIDTH-1:0] pos_sat;
  logic [VEL_W:0]              v_ext;
  logic [VEL_W:0]              mag;
  logic                        mag_hit;
  logic [NOW_W-1:0]            elapsed;
  logic                        to_motion;
  logic                        to_expand;
  logic                        grew_hi;
  logic                        grew_lo;
  logic                        fin_y;

  // divider
  logic             div_start;
  logic             div_sel_y;
  logic [POS_WIDTH-1:0] div_range;
  div_stat_t        div_stat;
  logic [DVD_W-1:0] div_quo;
  logic [SPD_W-1:0] spd;
  logic             out_load;
  logic             accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      motion_thr   <= RST_MOTION_THR;
      no_motion_ms <= RST_NO_MOTION;
      no_expand_ms <= RST_NO_EXPAND;
      speed_num    <= RST_SPEED_NUM;
      max_speed    <= RST_MAX_SPEED;
      min_speed    <= RST_MIN_SPEED;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MOTION_THR: motion_thr   <= cfg_data;
        CFG_NO_MOTION:  no_motion_ms <= cfg_data;
        CFG_NO_EXPAND:  no_expand_ms <= cfg_data;
        CFG_SPEED_NUM:  speed_num    <= cfg_data[NUM_W-1:0];
        CFG_MAX_SPEED:  max_speed    <= cfg_data[SPD_W-1:0];
        CFG_MIN_SPEED:  min_speed    <= cfg_data[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  assign axis_y  = (phase_q == PH_WAIT_Y) || (phase_q == PH_MEAS_Y);
  assign waiting = (phase_q == PH_WAIT_X) || (phase_q == PH_WAIT_Y);
  assign active  = waiting || (phase_q == PH_MEAS_X) || (phase_q == PH_MEAS_Y);

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= opcode;
      v_q   <= axis_y ? vel_y : vel_x;
      now_q <= now_ms;
    end
  end

  assign cur_pos = axis_y ? pos_y : pos_x;
  assign cur_max = axis_y ? pos_y_max : pos_x_max;
  assign cur_min = axis_y ? pos_y_min : pos_x_min;

  // saturating integration on one guard bit
  assign sum     = {cur_pos[POS_WIDTH-1], cur_pos}
                 + {{(POS_WIDTH+1-VEL_W){v_q[VEL_W-1]}}, v_q};
  assign pos_sat = (sum[POS_WIDTH] != sum[POS_WIDTH-1])
                 ? (sum[POS_WIDTH] ? POS_MIN : POS_MAX)
                 : sum[POS_WIDTH-1:0];

  assign v_ext     = {v_q[VEL_W-1], v_q};
  assign mag       = v_ext[VEL_W] ? (~v_ext + 1'b1) : v_ext;
  assign mag_hit   = mag > {1'b0, motion_thr};
  assign elapsed   = now_q - last_time;
  assign to_motion = elapsed > {{(NOW_W-CFG_W){1'b0}}, no_motion_ms};
  assign to_expand = elapsed > {{(NOW_W-CFG_W){1'b0}}, no_expand_ms};
  assign grew_hi   = cur_pos > cur_max;
  assign grew_lo   = cur_pos < cur_min;
  assign fin_y     = (phase_q == PH_MEAS_Y) && !grew_hi && !grew_lo && to_expand;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_q   <= PH_IDLE;
      pos_x     <= '0;
      pos_x_max <= '0;
      pos_x_min <= '0;
      pos_y     <= '0;
      pos_y_max <= '0;
      pos_y_min <= '0;
      last_time <= '0;
      speed_x_q <= '0;
      speed_y_q <= '0;
    end else begin
      unique case (st)
        ST_ACC: begin
          if (!op_q) begin
            pos_x     <= '0;
            pos_x_max <= '0;
            pos_x_min <= '0;
            pos_y     <= '0;
            pos_y_max <= '0;
            pos_y_min <= '0;
            last_time <= now_q;
            phase_q   <= PH_WAIT_X;
          end else if (active) begin
            if (axis_y) pos_y <= pos_sat;
            else        pos_x <= pos_sat;
          end
        end
        ST_EVAL: begin
          if (waiting) begin
            if (mag_hit) begin
              last_time <= now_q;
              phase_q   <= axis_y ? PH_MEAS_Y : PH_MEAS_X;
            end else if (to_motion) begin
              phase_q <= PH_ABORT;
            end
          end else begin
            if (grew_hi) begin
              if (axis_y) pos_y_max <= cur_pos;
              else        pos_x_max <= cur_pos;
            end
            if (grew_lo) begin
              if (axis_y) pos_y_min <= cur_pos;
              else        pos_x_min <= cur_pos;
            end
            // a widening restarts the timer and blocks the move on, even if the timer expired
            if (grew_hi || grew_lo || to_expand) last_time <= now_q;
            if (!grew_hi && !grew_lo && to_expand && !axis_y) phase_q <= PH_WAIT_Y;
          end
        end
        ST_DIV_X_RUN: begin
          if (div_stat.done) speed_x_q <= spd;
        end
        ST_DIV_Y_RUN: begin
          if (div_stat.done) begin
            speed_y_q <= spd;
            phase_q   <= PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) st <= ST_IDLE;
    else     st <= st_next;
  end

  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE:      if (in_valid) st_next = ST_ACC;
      ST_ACC:       st_next = (op_q && active) ? ST_EVAL : ST_FIN;
      ST_EVAL:      st_next = fin_y ? ST_DIV_X_GO : ST_FIN;
      ST_DIV_X_GO:  st_next = ST_DIV_X_RUN;
      ST_DIV_X_RUN: if (div_stat.done) st_next = ST_DIV_Y_GO;
      ST_DIV_Y_GO:  st_next = ST_DIV_Y_RUN;
      ST_DIV_Y_RUN: if (div_stat.done) st_next = ST_FIN;
      ST_FIN:       if (!out_valid || out_ready) st_next = ST_IDLE;
      default:      st_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (st == ST_IDLE);
    div_start = (st == ST_DIV_X_GO) || (st == ST_DIV_Y_GO);
    div_sel_y = (st == ST_DIV_Y_GO);
    out_load  = (st == ST_FIN) && (!out_valid || out_ready);
  end

  assign div_range = div_sel_y ? pos_y_max - pos_y_min : pos_x_max - pos_x_min;

  mrc_div #(
    .DVS_W (POS_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({speed_num, {FRAC_W{1'b0}}}),
    .divisor  (div_range),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // upper clamp is tested first, so it wins when the clamps are inverted
  always_comb begin
    if (div_quo > {{(DVD_W-SPD_W){1'b0}}, max_speed})
      spd = max_speed;
    else if (div_quo < {{(DVD_W-SPD_W){1'b0}}, min_speed})
      spd = min_speed;
    else
      spd = div_quo[SPD_W-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      phase       <= phase_q;
      speed_valid <= (phase_q == PH_DONE);
      speed_x     <= (phase_q == PH_DONE) ? speed_x_q : '0;
      speed_y     <= (phase_q == PH_DONE) ? speed_y_q : '0;
    end
  end

  a_div_quiet_when_ready : assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !div_stat.busy)
    else $error("divider busy while a new beat can be taken");

  a_x_range_brackets_zero : assert property (@(posedge clk) disable iff (rst)
    !pos_x_max[POS_WIDTH-1] && (pos_x_min[POS_WIDTH-1] || pos_x_min == '0))
    else $error("x range does not bracket the origin");

  a_done_after_y_div : assert property (@(posedge clk) disable iff (rst)
    (st == ST_DIV_Y_RUN && div_stat.done) |=> (phase_q == PH_DONE && st == ST_FIN))
    else $error("second division finished without reaching done");

endmodule
